// ----- rtl/slfa_pkg.sv -----
// Shared types and constants of the slot free list allocator.
`default_nettype none

package slfa_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // Slot fields are 6 bits wide, so no list ever holds a slot above this.
  localparam int unsigned POOL_MAX = 64;

  localparam logic [SLOT_W-1:0] FIRST_SLOT_RST = 6'd0;
  localparam logic [SLOT_W-1:0] LAST_SLOT_RST  = 6'd63;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 3'd0,
    KIND_FREE   = 3'd1,
    KIND_INIT   = 3'd2,
    KIND_RCLEAR = 3'd3,
    KIND_RSLOT  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_DOUBLE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SLOT = 1'd0,
    CFG_LAST_SLOT  = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INIT_WALK,
    ST_RS_LINK
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/slfa_if.sv -----
// Channel interfaces: command items, results and register writes.
`default_nettype none

interface slfa_item_if;
  import slfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic              prepared;
  modport source (output valid, kind, slot, prepared, input ready);
  modport sink   (input valid, kind, slot, prepared, output ready);
endinterface

interface slfa_result_if;
  import slfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_slot;
  logic [COUNT_W-1:0]  free_count;
  modport source (output valid, status, granted_slot, free_count, input ready);
  modport sink   (input valid, status, granted_slot, free_count, output ready);
endinterface

interface slfa_cfg_if;
  import slfa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SLOT_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/slfa_link_mem.sv -----
// Next-slot link memory: one write port, one read port, registered read data.
`default_nettype none

module slfa_link_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 7,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/slot_free_list_allocator_core.sv -----
// Top level of the LIFO slot free list allocator.
//
//  channel   | dir | beat fields                        | accepted when
//  ----------+-----+------------------------------------+---------------------
//  item_i    | in  | kind, slot, prepared               | valid && ready
//  result_o  | out | status, granted_slot, free_count   | valid && ready
//  cfg_i     | in  | index (0 first_slot, 1 last_slot), | valid && ready
//            |     | data                               |
//
// Steps: alloc, free, rebuild clear and unknown kinds are accepted, then
//   executed; rebuild of a free-going slot adds a link step after execute;
//   init adds, unless the range is empty, a walk that writes one link per cycle
//   from first to the clipped last slot. The single port pair of the link
//   memory and its registered read set these steps.
// Reset: control state, head, tail, count and free flags clear at once; the
//   link memory is not cleared and is only read at a head it already wrote.
// Stalls: a finished item parks in its last state while the result register
//   is full; the next item is taken once the block is back in idle.
`default_nettype none

module slot_free_list_allocator_core #(
  parameter int unsigned SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  slfa_item_if.sink     item_i,
  slfa_result_if.source result_o,
  slfa_cfg_if.sink      cfg_i
);

  import slfa_pkg::*;

  // Only slots below 64 can ever reach the list.
  localparam int unsigned MemDepth = (SLOTS < POOL_MAX) ? SLOTS : POOL_MAX;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned LinkW    = $clog2(SLOTS + 1);
  localparam logic [LinkW-1:0] Nil = LinkW'(SLOTS);

  // Control and list registers.
  state_e               state_q, state_d;
  logic [SLOT_W-1:0]    first_q, first_d;
  logic [SLOT_W-1:0]    last_q, last_d;
  logic [LinkW-1:0]     head_q, head_d;
  logic [LinkW-1:0]     tail_q, tail_d;
  logic [COUNT_W-1:0]   total_q, total_d;
  logic [MemDepth-1:0]  flags_q, flags_d;
  logic                 out_valid_q, out_valid_d;

  // Payload registers.
  kind_e                kind_q, kind_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 prep_q, prep_d;
  logic [SLOT_W-1:0]    walk_q, walk_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [SLOT_W-1:0]    res_granted_q, res_granted_d;
  logic [COUNT_W-1:0]   res_count_q, res_count_d;

  // Link memory port.
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic [LinkW-1:0]     mem_wdata;
  logic                 mem_re;
  logic [AddrW-1:0]     mem_raddr;
  logic [LinkW-1:0]     mem_rdata;

  logic                 out_free;
  logic                 emit;
  logic                 in_pool;
  logic [AddrW-1:0]     sidx;
  logic [SLOT_W-1:0]    hi_clip;

  slfa_link_mem #(
    .DEPTH (MemDepth),
    .WIDTH (LinkW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign item_i.ready          = (state_q == ST_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = out_valid_q;
  assign result_o.status       = res_status_q;
  assign result_o.granted_slot = res_granted_q;
  assign result_o.free_count   = res_count_q;

  assign out_free = !out_valid_q || result_o.ready;
  assign in_pool  = (32'(slot_q) < SLOTS);
  assign sidx     = slot_q[AddrW-1:0];
  // last_slot is clipped to the top of the pool.
  assign hi_clip  = (32'(last_q) > SLOTS - 1) ? SLOT_W'(SLOTS - 1) : last_q;

  // Register writes; the user must issue them only while the block is idle (not enforced here).
  always_comb begin
    first_d = first_q;
    last_d  = last_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_FIRST_SLOT: first_d = cfg_i.data;
        CFG_LAST_SLOT:  last_d  = cfg_i.data;
      endcase
    end
  end

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    total_d       = total_q;
    flags_d       = flags_q;
    kind_d        = kind_q;
    slot_d        = slot_q;
    prep_d        = prep_q;
    walk_d        = walk_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    res_count_d   = res_count_q;
    out_valid_d   = out_valid_q && !result_o.ready;
    emit          = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = sidx;
    mem_wdata     = Nil;
    // Alloc needs the link of the head: read it at accept.
    mem_re        = 1'b0;
    mem_raddr     = head_q[AddrW-1:0];

    // A waiting beat keeps its payload; a free result register starts clean.
    if (out_free) begin
      res_status_d  = STATUS_OK;
      res_granted_d = '0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          kind_d  = kind_e'(item_i.kind);
          slot_d  = item_i.slot;
          prep_d  = item_i.prepared;
          state_d = ST_EXEC;
          mem_re  = (kind_e'(item_i.kind) == KIND_ALLOC) && (head_q != Nil);
        end
      end

      ST_EXEC: begin
        unique case (kind_q)
          KIND_ALLOC: begin
            if (out_free) begin
              emit = 1'b1;
              if (total_q == '0 || head_q == Nil) begin
                res_status_d = STATUS_EMPTY;
              end else begin
                res_granted_d = SLOT_W'(head_q);
                flags_d[head_q[AddrW-1:0]] = 1'b0;
                total_d = total_q - 1'b1;
                if (mem_rdata >= Nil) begin
                  head_d = Nil;
                  tail_d = Nil;
                end else begin
                  head_d = mem_rdata;
                end
              end
            end
          end

          KIND_FREE: begin
            if (out_free) begin
              emit = 1'b1;
              if (in_pool) begin
                if (flags_q[sidx]) begin
                  res_status_d = STATUS_DOUBLE;
                end else begin
                  flags_d[sidx] = 1'b1;
                  mem_we    = 1'b1;
                  mem_wdata = head_q;
                  if (head_q == Nil) begin
                    tail_d = LinkW'(slot_q);
                  end
                  head_d  = LinkW'(slot_q);
                  total_d = total_q + 1'b1;
                end
              end
            end
          end

          KIND_INIT: begin
            if (first_q > hi_clip) begin
              if (out_free) begin
                emit    = 1'b1;
                flags_d = '0;
                head_d  = Nil;
                tail_d  = Nil;
                total_d = '0;
              end
            end else begin
              for (int i = 0; i < MemDepth; i++) begin
                flags_d[i] = (i >= int'(first_q)) && (i <= int'(hi_clip));
              end
              head_d  = LinkW'(first_q);
              tail_d  = LinkW'(hi_clip);
              total_d = COUNT_W'(hi_clip) - COUNT_W'(first_q) + 1'b1;
              walk_d  = first_q;
              state_d = ST_INIT_WALK;
            end
          end

          KIND_RCLEAR: begin
            if (out_free) begin
              emit    = 1'b1;
              flags_d = '0;
              head_d  = Nil;
              tail_d  = Nil;
              total_d = '0;
            end
          end

          KIND_RSLOT: begin
            if (in_pool && !flags_q[sidx] && !prep_q) begin
              // Terminate the new tail now, hook it on next cycle.
              mem_we    = 1'b1;
              mem_wdata = Nil;
              state_d   = ST_RS_LINK;
            end else if (out_free) begin
              emit = 1'b1;
              if (in_pool && flags_q[sidx]) begin
                res_status_d = STATUS_DOUBLE;
              end
            end
          end

          default: begin
            if (out_free) begin
              emit = 1'b1;
            end
          end
        endcase
      end

      ST_INIT_WALK: begin
        // Rewriting the last link while the result waits is harmless.
        mem_we    = 1'b1;
        mem_waddr = walk_q[AddrW-1:0];
        mem_wdata = (walk_q == hi_clip) ? Nil : LinkW'(walk_q) + 1'b1;
        if (walk_q != hi_clip) begin
          walk_d = walk_q + 1'b1;
        end else if (out_free) begin
          emit = 1'b1;
        end
      end

      ST_RS_LINK: begin
        if (tail_q != Nil) begin
          mem_we    = 1'b1;
          mem_waddr = tail_q[AddrW-1:0];
          mem_wdata = LinkW'(slot_q);
        end
        if (out_free) begin
          emit = 1'b1;
          if (head_q == Nil) begin
            head_d = LinkW'(slot_q);
          end
          tail_d        = LinkW'(slot_q);
          flags_d[sidx] = 1'b1;
          total_d       = total_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      res_count_d = total_d;
      state_d     = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= FIRST_SLOT_RST;
      last_q      <= LAST_SLOT_RST;
      head_q      <= Nil;
      tail_q      <= Nil;
      total_q     <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      total_q     <= total_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    slot_q        <= slot_d;
    prep_q        <= prep_d;
    walk_q        <= walk_d;
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    res_count_q   <= res_count_d;
  end

  // An empty list has neither head nor tail, and only then.
  ast_head_tail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == Nil) == (tail_q == Nil))
    else $error("head and tail disagree on an empty list");

  ast_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == Nil) == (total_q == '0))
    else $error("free count disagrees with list head");

  ast_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= MemDepth)
    else $error("free count exceeds pool");

  ast_grant_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && kind_q == KIND_ALLOC && out_free && head_q != Nil
     && total_q != '0) |=> !flags_q[$past(head_q[AddrW-1:0])])
    else $error("granted slot still marked free");

endmodule

`default_nettype wire
